@@ sv/m7tw_pkg.sv @@
// m7tw_pkg: shared types and constants of the mode-7 row texel walker
// no dependencies; the files that use it refer to it by scoped names
`default_nettype none

package m7tw_pkg;

    // command opcodes carried on the command channel
    typedef enum logic [1:0] {
        OP_LOAD_TEXEL   = 2'd0,
        OP_LOAD_PALETTE = 2'd1,
        OP_START_ROW    = 2'd2,
        OP_EMIT_PIXEL   = 2'd3
    } opcode_t;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_X     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Y     = 3'd5;

    // field widths
    localparam int ACC_W    = 32;
    localparam int SHIFT_W  = 5;
    localparam int LOG_W    = 4;
    localparam int INDEX_W  = 16;
    localparam int TEXEL_W  = 8;
    localparam int COLOR_W  = 16;
    localparam int PAL_DEPTH = 256;

    // reset values of the configuration registers
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;
    localparam logic [LOG_W-1:0]   LOG_RESET   = 4'd8;

    // configuration register set
    typedef struct packed {
        logic [SHIFT_W-1:0]      shift_x;
        logic [SHIFT_W-1:0]      shift_y;
        logic [LOG_W-1:0]        log_width;
        logic [LOG_W-1:0]        log_height;
        logic signed [ACC_W-1:0] step_x;
        logic signed [ACC_W-1:0] step_y;
    } cfg_t;

    // item held between the texture stage and the palette stage
    typedef struct packed {
        logic               is_pal_load;
        logic [7:0]         pal_index;
        logic [COLOR_W-1:0] color;
        logic [TEXEL_W-1:0] texel;
    } stage_item_t;

endpackage

`default_nettype wire

@@ sv/m7tw_cmd_if.sv @@
// m7tw_cmd_if: command channel of the texel walker (valid/ready plus payload)
// depends on nothing
`default_nettype none

interface m7tw_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] write_index;
    logic [7:0]  texel_value;
    logic [15:0] color_value;
    logic [31:0] start_x;
    logic [31:0] start_y;

    modport source (
        output valid, opcode, write_index, texel_value, color_value, start_x, start_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, write_index, texel_value, color_value, start_x, start_y,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/m7tw_pixel_if.sv @@
// m7tw_pixel_if: pixel result channel of the texel walker (valid/ready plus color)
// depends on nothing
`default_nettype none

interface m7tw_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;

    modport source (
        output valid, pixel_color,
        input  ready
    );

    modport sink (
        input  valid, pixel_color,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/m7tw_cfg_regs.sv @@
// m7tw_cfg_regs: configuration register file of the texel walker
// depends on m7tw_pkg
`default_nettype none

module m7tw_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [m7tw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [m7tw_pkg::CFG_DATA_W-1:0]    cfg_data,
    output m7tw_pkg::cfg_t                          cfg
);

    m7tw_pkg::cfg_t cfg_reg;
    m7tw_pkg::cfg_t cfg_next;

    // register write decode, each register keeps its low bits
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                m7tw_pkg::CFG_SHIFT_X:
                    cfg_next.shift_x = cfg_data[m7tw_pkg::SHIFT_W-1:0];
                m7tw_pkg::CFG_SHIFT_Y:
                    cfg_next.shift_y = cfg_data[m7tw_pkg::SHIFT_W-1:0];
                m7tw_pkg::CFG_LOG_WIDTH:
                    cfg_next.log_width = cfg_data[m7tw_pkg::LOG_W-1:0];
                m7tw_pkg::CFG_LOG_HEIGHT:
                    cfg_next.log_height = cfg_data[m7tw_pkg::LOG_W-1:0];
                m7tw_pkg::CFG_STEP_X:
                    cfg_next.step_x = cfg_data[m7tw_pkg::ACC_W-1:0];
                m7tw_pkg::CFG_STEP_Y:
                    cfg_next.step_y = cfg_data[m7tw_pkg::ACC_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_x    <= m7tw_pkg::SHIFT_RESET;
            cfg_reg.shift_y    <= m7tw_pkg::SHIFT_RESET;
            cfg_reg.log_width  <= m7tw_pkg::LOG_RESET;
            cfg_reg.log_height <= m7tw_pkg::LOG_RESET;
            cfg_reg.step_x     <= '0;
            cfg_reg.step_y     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/m7tw_walker.sv @@
// m7tw_walker: x/y accumulators and texel index generation
// depends on m7tw_pkg
`default_nettype none

module m7tw_walker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire m7tw_pkg::cfg_t                    cfg,
    input  wire logic                              accept,
    input  wire logic [1:0]                        opcode,
    input  wire logic [m7tw_pkg::ACC_W-1:0]        start_x,
    input  wire logic [m7tw_pkg::ACC_W-1:0]        start_y,
    output logic [m7tw_pkg::INDEX_W-1:0]           tex_index
);

    logic [m7tw_pkg::ACC_W-1:0]   acc_x_reg;
    logic [m7tw_pkg::ACC_W-1:0]   acc_y_reg;
    logic [m7tw_pkg::ACC_W-1:0]   acc_x_next;
    logic [m7tw_pkg::ACC_W-1:0]   acc_y_next;
    logic [m7tw_pkg::INDEX_W:0]   col_mask_wide;
    logic [m7tw_pkg::INDEX_W:0]   row_mask_wide;
    logic [m7tw_pkg::INDEX_W-1:0] col;
    logic [m7tw_pkg::INDEX_W-1:0] row;

    // column and row from the accumulators; only the low index bits survive the wrap
    always_comb
    begin
        col_mask_wide = (17'd1 << cfg.log_width) - 17'd1;
        row_mask_wide = (17'd1 << cfg.log_height) - 17'd1;
        col = m7tw_pkg::INDEX_W'(acc_x_reg >> cfg.shift_x)
              & col_mask_wide[m7tw_pkg::INDEX_W-1:0];
        row = m7tw_pkg::INDEX_W'(acc_y_reg >> cfg.shift_y)
              & row_mask_wide[m7tw_pkg::INDEX_W-1:0];
        tex_index = col + m7tw_pkg::INDEX_W'(row << cfg.log_width);
    end

    // row start loads, pixel beats step by the signed increments
    always_comb
    begin
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        if (accept)
        begin
            case (opcode)
                m7tw_pkg::OP_START_ROW:
                begin
                    acc_x_next = start_x;
                    acc_y_next = start_y;
                end
                m7tw_pkg::OP_EMIT_PIXEL:
                begin
                    acc_x_next = acc_x_reg + unsigned'(cfg.step_x);
                    acc_y_next = acc_y_reg + unsigned'(cfg.step_y);
                end
                default:
                begin
                    acc_x_next = acc_x_reg;
                    acc_y_next = acc_y_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/m7tw_tex_stage.sv @@
// m7tw_tex_stage: texture memory and the stage register in front of the palette
// depends on m7tw_pkg
`default_nettype none

module m7tw_tex_stage #(
    parameter int TEX_DEPTH = 65536
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [1:0]                        opcode,
    input  wire logic [m7tw_pkg::INDEX_W-1:0]      write_index,
    input  wire logic [m7tw_pkg::TEXEL_W-1:0]      texel_value,
    input  wire logic [m7tw_pkg::COLOR_W-1:0]      color_value,
    input  wire logic [m7tw_pkg::INDEX_W-1:0]      rd_index,
    input  wire logic                              next_free,
    output logic                                   item_valid,
    output m7tw_pkg::stage_item_t                  item
);

    // the user must give a power-of-two texture depth (not checked here), so wrapping is a mask
    localparam int TEX_AW = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
    localparam logic [TEX_AW-1:0] TEX_MASK = TEX_AW'(TEX_DEPTH - 1);

    logic [m7tw_pkg::TEXEL_W-1:0] tex_mem [TEX_DEPTH];
    logic [m7tw_pkg::TEXEL_W-1:0] texel_reg;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         is_pal_reg;
    logic [7:0]                   pal_index_reg;
    logic [m7tw_pkg::COLOR_W-1:0] color_reg;
    logic [TEX_AW-1:0]            waddr;
    logic [TEX_AW-1:0]            raddr;
    logic                         is_load_texel;
    logic                         is_load_pal;
    logic                         is_emit;

    assign is_load_texel = (opcode == m7tw_pkg::OP_LOAD_TEXEL);
    assign is_load_pal   = (opcode == m7tw_pkg::OP_LOAD_PALETTE);
    assign is_emit       = (opcode == m7tw_pkg::OP_EMIT_PIXEL);
    assign waddr = write_index[TEX_AW-1:0] & TEX_MASK;
    assign raddr = rd_index[TEX_AW-1:0] & TEX_MASK;

    // texture write on load beats, registered read on pixel beats
    always_ff @(posedge clk)
    begin
        if (accept && is_load_texel)
        begin
            tex_mem[waddr] <= texel_value;
        end
        if (accept && is_emit)
        begin
            texel_reg <= tex_mem[raddr];
        end
    end

    // only palette loads and pixels go on to the palette stage
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = is_load_pal || is_emit;
        end
        else if (next_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload of the held beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_pal_reg    <= is_load_pal;
            pal_index_reg <= write_index[7:0];
            color_reg     <= color_value;
        end
    end

    assign item_valid       = valid_reg;
    assign item.is_pal_load = is_pal_reg;
    assign item.pal_index   = pal_index_reg;
    assign item.color       = color_reg;
    assign item.texel       = texel_reg;

endmodule

`default_nettype wire

@@ sv/m7tw_pal_stage.sv @@
// m7tw_pal_stage: palette memory and the pixel output register
// depends on m7tw_pkg
`default_nettype none

module m7tw_pal_stage (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    input  wire m7tw_pkg::stage_item_t             item,
    input  wire logic                              out_ready,
    output logic                                   free,
    output logic                                   out_valid,
    output logic [m7tw_pkg::COLOR_W-1:0]           out_color
);

    logic [m7tw_pkg::COLOR_W-1:0] pal_mem [m7tw_pkg::PAL_DEPTH];
    logic [m7tw_pkg::COLOR_W-1:0] color_reg;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         take;

    // output register empties or drains this cycle
    assign free = !valid_reg || out_ready;
    assign take = item_valid && free;

    // palette writes and reads happen in beat order at this stage
    always_ff @(posedge clk)
    begin
        if (take && item.is_pal_load)
        begin
            pal_mem[item.pal_index] <= item.color;
        end
        if (take && !item.is_pal_load)
        begin
            color_reg <= pal_mem[item.texel];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = !item.is_pal_load;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

@@ sv/mode7_row_texel_walker_top.sv @@
// mode7_row_texel_walker_top: mode-7 row texel walker, top level
// depends on m7tw_pkg, m7tw_cmd_if, m7tw_pixel_if and the m7tw_* submodules
//
// Usage:
// - cmd carries one command per beat: load texel, load palette entry, start
//   row (set both accumulators) or emit pixel. Only emit pixel gives a beat
//   on pixel, with the palette color of the texel under the accumulators.
// - cfg_we/cfg_index/cfg_data write the shift, size and step registers, one
//   register per cycle, while no command is in flight.
// - Throughput is one command per cycle while pixel does not stall. A pixel
//   beat reads the texture memory into the stage register when it is
//   accepted, then reads the palette into the output register, from which
//   it is shown on pixel.
// - Reset clears the accumulators, returns the registers to their reset
//   values and empties the pipeline; texture and palette contents stay
//   undefined until loaded.
// - When pixel stalls, the result waits in the output register and one more
//   command is held in front of the palette; cmd.ready then follows
//   pixel.ready until the output drains.
`default_nettype none

module mode7_row_texel_walker_top #(
    parameter int TEX_DEPTH = 65536
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    m7tw_cmd_if.sink                                cmd,
    m7tw_pixel_if.source                            pixel,
    input  wire logic                               cfg_we,
    input  wire logic [m7tw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [m7tw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    m7tw_pkg::cfg_t               cfg;
    m7tw_pkg::stage_item_t        item;
    logic                         item_valid;
    logic                         pal_free;
    logic                         accept;
    logic [m7tw_pkg::INDEX_W-1:0] tex_index;

    // a command enters when the stage register is empty or moving on
    assign cmd.ready = !item_valid || pal_free;
    assign accept    = cmd.valid && cmd.ready;

    m7tw_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    m7tw_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .opcode    (cmd.opcode),
        .start_x   (cmd.start_x),
        .start_y   (cmd.start_y),
        .tex_index (tex_index)
    );

    m7tw_tex_stage #(
        .TEX_DEPTH (TEX_DEPTH)
    ) u_tex_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (cmd.opcode),
        .write_index (cmd.write_index),
        .texel_value (cmd.texel_value),
        .color_value (cmd.color_value),
        .rd_index    (tex_index),
        .next_free   (pal_free),
        .item_valid  (item_valid),
        .item        (item)
    );

    m7tw_pal_stage u_pal_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (pixel.ready),
        .free       (pal_free),
        .out_valid  (pixel.valid),
        .out_color  (pixel.pixel_color)
    );

endmodule

`default_nettype wire

@@ tb/m7tw_color_check.sv @@
// m7tw_color_check: watches the command, pixel and register-write ports of the texel walker
// keeps its own texture, palette, accumulators and registers, and compares every pixel beat
// depends on m7tw_pkg, m7tw_cmd_if and m7tw_pixel_if
module m7tw_color_check (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    m7tw_cmd_if                                   cmd,
    m7tw_pixel_if                                 pixel,
    input  wire logic                             cfg_we,
    input  wire logic [m7tw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [m7tw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                           fail_count,
    output int unsigned                           colors_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX_ENTRIES = 65536;
    localparam int MAX_SHOWN   = 10;

    m7tw_pkg::cfg_t                         regs;
    logic [m7tw_pkg::ACC_W-1:0]             pos_u;
    logic [m7tw_pkg::ACC_W-1:0]             pos_v;
    logic [m7tw_pkg::TEXEL_W-1:0]           tex_mem [TEX_ENTRIES];
    logic [m7tw_pkg::COLOR_W-1:0]           clut [m7tw_pkg::PAL_DEPTH];
    logic [m7tw_pkg::COLOR_W-1:0]           expected_colors [$];
    logic [m7tw_pkg::COLOR_W-1:0]           want_color;

    // texel address under the current accumulators, wrapped to the texture size
    function automatic logic [m7tw_pkg::INDEX_W-1:0] sample_addr();
        logic [31:0] col;
        logic [31:0] row;
        logic [31:0] sum;
        col = (pos_u >> regs.shift_x) & ((32'd1 << regs.log_width) - 32'd1);
        row = (pos_v >> regs.shift_y) & ((32'd1 << regs.log_height) - 32'd1);
        sum = col + (row << regs.log_width);
        return sum[m7tw_pkg::INDEX_W-1:0];
    endfunction

    task automatic flag_error(input string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.shift_x    = m7tw_pkg::SHIFT_RESET;
            regs.shift_y    = m7tw_pkg::SHIFT_RESET;
            regs.log_width  = m7tw_pkg::LOG_RESET;
            regs.log_height = m7tw_pkg::LOG_RESET;
            regs.step_x     = '0;
            regs.step_y     = '0;
            pos_u           = '0;
            pos_v           = '0;
            expected_colors.delete();
            fail_count      = 0;
        end
        else
        begin
            // register writes keep only the low bits of the data
            if (cfg_we)
            begin
                case (cfg_index)
                    m7tw_pkg::CFG_SHIFT_X:    regs.shift_x    = cfg_data[m7tw_pkg::SHIFT_W-1:0];
                    m7tw_pkg::CFG_SHIFT_Y:    regs.shift_y    = cfg_data[m7tw_pkg::SHIFT_W-1:0];
                    m7tw_pkg::CFG_LOG_WIDTH:  regs.log_width  = cfg_data[m7tw_pkg::LOG_W-1:0];
                    m7tw_pkg::CFG_LOG_HEIGHT: regs.log_height = cfg_data[m7tw_pkg::LOG_W-1:0];
                    m7tw_pkg::CFG_STEP_X:     regs.step_x     = cfg_data;
                    m7tw_pkg::CFG_STEP_Y:     regs.step_y     = cfg_data;
                    default: ;
                endcase
            end

            // pixel beat against the oldest expected color
            if (pixel.valid && pixel.ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    flag_error($sformatf("pixel beat with no color expected: got %h",
                                         pixel.pixel_color));
                end
                else
                begin
                    want_color = expected_colors.pop_front();
                    if (pixel.pixel_color !== want_color)
                    begin
                        flag_error($sformatf("pixel_color mismatch: expected %h got %h",
                                             want_color, pixel.pixel_color));
                    end
                end
            end

            // command beat updates the stores or walks one pixel
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.opcode)
                    m7tw_pkg::OP_LOAD_TEXEL:   tex_mem[cmd.write_index] = cmd.texel_value;
                    m7tw_pkg::OP_LOAD_PALETTE: clut[cmd.write_index[7:0]] = cmd.color_value;
                    m7tw_pkg::OP_START_ROW:
                    begin
                        pos_u = cmd.start_x;
                        pos_v = cmd.start_y;
                    end
                    m7tw_pkg::OP_EMIT_PIXEL:
                    begin
                        expected_colors.push_back(clut[tex_mem[sample_addr()]]);
                        pos_u = pos_u + regs.step_x;
                        pos_v = pos_v + regs.step_y;
                    end
                    default: ;
                endcase
            end
        end
        colors_pending = expected_colors.size();
    end

endmodule

@@ tb/mode7_row_texel_walker_top_tb.sv @@
// mode7_row_texel_walker_top_tb: stimulus and verdict for the mode-7 row texel walker
// depends on m7tw_pkg, m7tw_cmd_if, m7tw_pixel_if, m7tw_color_check and the block itself
// directed corners first, then random register settings with rows of pixels and loads
module mode7_row_texel_walker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1650;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 250000;

    // indexes past the end of the register list, writes there must do nothing
    localparam logic [m7tw_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [m7tw_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [m7tw_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [m7tw_pkg::CFG_DATA_W-1:0]    cfg_data;
    int unsigned                        check_fails;
    int unsigned                        colors_pending;
    int unsigned                        cycle_count = 0;
    int unsigned                        items_sent = 0;
    bit                                 no_idle = 1'b0;
    int unsigned                        sink_draw;
    logic [1:0]                         sink_wait;

    // shadow of the registers and accumulators, used to know which texels a row reads
    logic [4:0]                         cur_shift_x;
    logic [4:0]                         cur_shift_y;
    logic [3:0]                         cur_log_w;
    logic [3:0]                         cur_log_h;
    logic [31:0]                        cur_step_x;
    logic [31:0]                        cur_step_y;
    logic [31:0]                        walk_x;
    logic [31:0]                        walk_y;
    bit                                 texel_loaded [65536];

    m7tw_cmd_if   cmd_bus ();
    m7tw_pixel_if pixel_bus ();

    mode7_row_texel_walker_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .pixel     (pixel_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    m7tw_color_check i_color_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_bus),
        .pixel          (pixel_bus),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (check_fails),
        .colors_pending (colors_pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // pixel sink: after each beat ready may drop for a random wait drawn into sink_wait; with no_idle it stays high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bus.ready <= 1'b0;
            sink_wait       <= 2'd0;
        end
        else if (pixel_bus.valid && pixel_bus.ready)
        begin
            sink_draw = no_idle ? 0 : $urandom_range(0, 3);
            pixel_bus.ready <= (sink_draw == 0);
            sink_wait       <= 2'(sink_draw);
        end
        else if (!pixel_bus.ready)
        begin
            if (sink_wait <= 2'd1)
            begin
                pixel_bus.ready <= 1'b1;
                sink_wait       <= 2'd0;
            end
            else
            begin
                sink_wait <= sink_wait - 2'd1;
            end
        end
    end

    // texel that the next pixel beat will read
    function automatic logic [15:0] walk_addr();
        logic [31:0] col;
        logic [31:0] row;
        logic [31:0] sum;
        col = (walk_x >> cur_shift_x) & ((32'd1 << cur_log_w) - 32'd1);
        row = (walk_y >> cur_shift_y) & ((32'd1 << cur_log_h) - 32'd1);
        sum = col + (row << cur_log_w);
        return sum[15:0];
    endfunction

    // one command beat after a random gap; valid stays high when the gap is zero
    task automatic send_cmd(input m7tw_pkg::opcode_t op, input logic [15:0] widx,
                            input logic [7:0] tval, input logic [15:0] cval,
                            input logic [31:0] x0, input logic [31:0] y0);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.opcode      <= op;
        cmd_bus.write_index <= widx;
        cmd_bus.texel_value <= tval;
        cmd_bus.color_value <= cval;
        cmd_bus.start_x     <= x0;
        cmd_bus.start_y     <= y0;
        do @(posedge clk); while (!cmd_bus.ready);
        items_sent++;
    endtask

    task automatic load_texel(input logic [15:0] idx, input logic [7:0] val);
        send_cmd(m7tw_pkg::OP_LOAD_TEXEL, idx, val, 16'($urandom), $urandom, $urandom);
        texel_loaded[idx] = 1'b1;
    endtask

    task automatic load_color(input logic [15:0] idx, input logic [15:0] val);
        send_cmd(m7tw_pkg::OP_LOAD_PALETTE, idx, 8'($urandom), val, $urandom, $urandom);
    endtask

    task automatic start_row(input logic [31:0] x0, input logic [31:0] y0);
        send_cmd(m7tw_pkg::OP_START_ROW, 16'($urandom), 8'($urandom), 16'($urandom), x0, y0);
        walk_x = x0;
        walk_y = y0;
    endtask

    // a texel is loaded just ahead of the pixel that first reads it
    task automatic emit_pixel();
        logic [15:0] addr;
        addr = walk_addr();
        if (!texel_loaded[addr])
        begin
            load_texel(addr, 8'($urandom));
        end
        send_cmd(m7tw_pkg::OP_EMIT_PIXEL, 16'($urandom), 8'($urandom), 16'($urandom),
                 $urandom, $urandom);
        walk_x = walk_x + cur_step_x;
        walk_y = walk_y + cur_step_y;
    endtask

    task automatic noise_load();
        if ($urandom_range(0, 1) == 0)
        begin
            load_texel(16'($urandom), 8'($urandom));
        end
        else
        begin
            load_color(16'($urandom), 16'($urandom));
        end
    endtask

    // a row of pixels, optionally without a fresh start, with loads mixed in
    task automatic run_row(input int unsigned pixels, input bit restart);
        if (restart)
        begin
            start_row($urandom, $urandom);
        end
        repeat (pixels)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise_load();
            end
            emit_pixel();
        end
    endtask

    // drop valid, wait for every pixel to come back, then let the pipeline empty
    task automatic settle(input int unsigned cycles);
        cmd_bus.valid <= 1'b0;
        do @(posedge clk); while (colors_pending != 0);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [m7tw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            m7tw_pkg::CFG_SHIFT_X:    cur_shift_x = data[4:0];
            m7tw_pkg::CFG_SHIFT_Y:    cur_shift_y = data[4:0];
            m7tw_pkg::CFG_LOG_WIDTH:  cur_log_w   = data[3:0];
            m7tw_pkg::CFG_LOG_HEIGHT: cur_log_h   = data[3:0];
            m7tw_pkg::CFG_STEP_X:     cur_step_x  = data;
            m7tw_pkg::CFG_STEP_Y:     cur_step_y  = data;
            default: ;
        endcase
    endtask

    // full register set with junk in the unused upper bits, plus one spare index
    task automatic set_config(input logic [4:0] sx, input logic [4:0] sy,
                              input logic [3:0] lw, input logic [3:0] lh,
                              input logic [31:0] stx, input logic [31:0] sty);
        logic [31:0] junk;
        settle(SETTLE_CYCLES);
        junk = $urandom;
        write_reg(m7tw_pkg::CFG_SHIFT_X, {junk[31:5], sx});
        junk = $urandom;
        write_reg(m7tw_pkg::CFG_SHIFT_Y, {junk[31:5], sy});
        junk = $urandom;
        write_reg(m7tw_pkg::CFG_LOG_WIDTH, {junk[31:4], lw});
        junk = $urandom;
        write_reg(m7tw_pkg::CFG_LOG_HEIGHT, {junk[31:4], lh});
        write_reg(m7tw_pkg::CFG_STEP_X, stx);
        write_reg(m7tw_pkg::CFG_STEP_Y, sty);
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] pick_log();
        if ($urandom_range(0, 7) == 0)
        begin
            return 4'($urandom_range(9, 15));
        end
        return 4'($urandom_range(0, 8));
    endfunction

    function automatic logic [31:0] pick_step();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return 32'($signed($urandom) >>> $urandom_range(0, 31));
    endfunction

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.opcode      <= m7tw_pkg::OP_LOAD_TEXEL;
        cmd_bus.write_index <= '0;
        cmd_bus.texel_value <= '0;
        cmd_bus.color_value <= '0;
        cmd_bus.start_x     <= '0;
        cmd_bus.start_y     <= '0;
        cur_shift_x = m7tw_pkg::SHIFT_RESET;
        cur_shift_y = m7tw_pkg::SHIFT_RESET;
        cur_log_w   = m7tw_pkg::LOG_RESET;
        cur_log_h   = m7tw_pkg::LOG_RESET;
        cur_step_x  = '0;
        cur_step_y  = '0;
        walk_x      = '0;
        walk_y      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // whole palette defined up front, upper index bits random
        for (int i = 0; i < m7tw_pkg::PAL_DEPTH; i++)
        begin
            load_color({8'($urandom), 8'(i)}, 16'($urandom));
        end

        // corners under the reset register values
        load_texel(16'h0000, 8'hFF);
        load_texel(16'hFFFF, 8'h00);
        load_color(16'hFFFF, 16'hFFFF);
        load_color(16'h0100, 16'h0000);
        emit_pixel();
        start_row(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        emit_pixel();
        load_color(16'hAB00, 16'h5A5A);
        emit_pixel();
        load_texel(16'hFFFF, 8'hFF);
        emit_pixel();
        start_row(32'h0000_0000, 32'h0000_0000);
        emit_pixel();

        // register extremes: zero and full shifts, empty and oversized textures
        set_config(5'd0, 5'd31, 4'd0, 4'd8, 32'h8000_0000, 32'h7FFF_FFFF);
        run_row(3, 1'b1);
        set_config(5'd31, 5'd0, 4'd15, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000);
        run_row(3, 1'b1);
        set_config(5'd4, 5'd4, 4'd8, 4'd0, 32'h0000_0010, 32'hFFFF_FFF0);
        run_row(3, 1'b1);

        // random settings, mostly well-formed rows with some broken ones and stray loads
        while (items_sent < ITEM_TARGET)
        begin
            set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       pick_log(), pick_log(), pick_step(), pick_step());
            no_idle <= ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 6))
            begin
                case ($urandom_range(0, 9))
                    0, 1:    noise_load();
                    2:       run_row($urandom_range(1, 8), 1'b0);
                    default: run_row($urandom_range(1, 16), 1'b1);
                endcase
            end
        end

        settle(DRAIN_CYCLES);
        if (check_fails == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/m7tw_pkg.sv
sv/m7tw_cmd_if.sv
sv/m7tw_pixel_if.sv
sv/m7tw_cfg_regs.sv
sv/m7tw_walker.sv
sv/m7tw_tex_stage.sv
sv/m7tw_pal_stage.sv
sv/mode7_row_texel_walker_top.sv
tb/m7tw_color_check.sv
tb/mode7_row_texel_walker_top_tb.sv
